@@ rtl/ocdd_pkg.sv @@
// package for the one's-complement double-length divider
// holds the pipeline word types, constants and the end-around-carry helpers
// no dependencies
`timescale 1ns / 1ps

package ocdd_pkg;

  localparam int WordWidth      = 16;
  localparam int Rounds         = 14;
  localparam int RoundsPerStage = 2;
  localparam int RoundStages    = Rounds / RoundsPerStage;

  localparam logic [WordWidth-1:0] Bias    = 16'o040000;
  localparam logic [WordWidth-1:0] AllOnes = 16'o177777;
  localparam logic [WordWidth-1:0] One     = 16'd1;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    word_t q;
    word_t rem;
    word_t dvs;
    logic  q_sign;
    logic  dvd_sign;
    logic  dvs_sign;
  } work_t;

  typedef struct packed {
    word_t remainder_word;
    word_t quotient_word;
  } result_t;

  function automatic word_t eac_add(word_t x, word_t y);
    logic [WordWidth:0] s;
    s = {1'b0, x} + {1'b0, y};
    eac_add = s[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, s[WordWidth]};
  endfunction

  // one shift-and-add step of the divide sequence
  function automatic work_t div_round(work_t w);
    work_t r;
    word_t q;
    word_t rem;
    word_t sum;
    logic  r_sign;
    r      = w;
    q      = {w.q[WordWidth-2:0], 1'b0};
    r_sign = w.rem[WordWidth-1];
    rem    = {r_sign, w.rem[WordWidth-3:0], 1'b0};
    if (!q[WordWidth-1]) begin
      rem[0] = r_sign;
    end
    sum = eac_add(rem, w.dvs);
    if (sum[WordWidth-1]) begin
      q[0] = 1'b1;
      rem  = sum;
    end
    r.q   = q;
    r.rem = rem;
    div_round = r;
  endfunction

endpackage

@@ rtl/ocdd_prep.sv @@
// input stage: sign extraction, magnitudes, lower word bias and quotient seed
// depends on ocdd_pkg
`timescale 1ns / 1ps

module ocdd_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ocdd_pkg::word_t    upper_word,
  input  ocdd_pkg::word_t    lower_word,
  input  ocdd_pkg::word_t    divisor_word,
  output logic               out_valid,
  input  logic               out_ready,
  output ocdd_pkg::work_t    out_data
);

  ocdd_pkg::work_t data_next;
  ocdd_pkg::word_t a1;
  ocdd_pkg::word_t l1;
  ocdd_pkg::word_t l2;
  logic            dvd_sign;

  always_comb begin
    dvd_sign = upper_word[15];
    a1       = dvd_sign ? upper_word : ~upper_word;
    if (a1 == ocdd_pkg::AllOnes) begin
      dvd_sign = lower_word[15];
    end
    l1 = dvd_sign ? ~lower_word : lower_word;
    l2 = ocdd_pkg::eac_add(l1, ocdd_pkg::Bias);

    data_next.dvd_sign = dvd_sign;
    data_next.rem      = (l2[15:14] == 2'b01) ? a1 : ocdd_pkg::eac_add(a1, ocdd_pkg::One);
    data_next.dvs_sign = divisor_word[15];
    data_next.dvs      = divisor_word[15] ? ~divisor_word : divisor_word;
    data_next.q_sign   = l2[15];
    data_next.q        = {l2[15], l2[13:0], l2[15]};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ rtl/ocdd_round_stage.sv @@
// one pipeline stage running a fixed number of divide rounds
// depends on ocdd_pkg
`timescale 1ns / 1ps

module ocdd_round_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ocdd_pkg::work_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ocdd_pkg::work_t    out_data
);

  ocdd_pkg::work_t data_next;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < ocdd_pkg::RoundsPerStage; i++) begin
      data_next = ocdd_pkg::div_round(data_next);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ rtl/ocdd_post.sv @@
// output stage: applies result signs and holds the result register
// depends on ocdd_pkg
`timescale 1ns / 1ps

module ocdd_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ocdd_pkg::work_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ocdd_pkg::result_t  out_data
);

  ocdd_pkg::result_t data_next;
  ocdd_pkg::word_t   res_a;

  always_comb begin
    res_a = {in_data.q_sign, in_data.q[14:0]};
    data_next.quotient_word  = (in_data.dvd_sign != in_data.dvs_sign) ? ~res_a : res_a;
    data_next.remainder_word = in_data.dvd_sign ? in_data.rem : ~in_data.rem;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ rtl/ones_complement_double_divide_top.sv @@
// pipeline: prep, 7 round stages of 2 end-around-carry rounds each, sign stage
// throughput: one transaction per cycle while m_axis_tready is high; a stall holds each full stage in place
// reset: synchronous active-high rst clears all stage valid bits
// depends on ocdd_pkg, ocdd_prep, ocdd_round_stage, ocdd_post
`timescale 1ns / 1ps

module ones_complement_double_divide_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // upper_word, lower_word, divisor_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // quotient_word, remainder_word
);

  localparam int N = ocdd_pkg::RoundStages;

  logic              valid [N+1];
  logic              ready [N+1];
  ocdd_pkg::work_t   data  [N+1];
  ocdd_pkg::result_t result;

  ocdd_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .upper_word   (s_axis_tdata[15:0]),
    .lower_word   (s_axis_tdata[31:16]),
    .divisor_word (s_axis_tdata[47:32]),
    .out_valid    (valid[0]),
    .out_ready    (ready[0]),
    .out_data     (data[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_round
    ocdd_round_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_ready  (ready[g]),
      .in_data   (data[g]),
      .out_valid (valid[g+1]),
      .out_ready (ready[g+1]),
      .out_data  (data[g+1])
    );
  end

  ocdd_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[N]),
    .in_ready  (ready[N]),
    .in_data   (data[N]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (result)
  );

  assign m_axis_tdata = {result.remainder_word, result.quotient_word};

endmodule
